// ===== sv/sitd_pkg.sv =====
// Package for the signed integer to decimal text block: constants, control word
// types and the microprogram table used by the sequencer and the datapath.
// Depends on nothing.
package sitd_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_W);
  localparam int unsigned ND_W       = 4;
  localparam int unsigned STEP_W     = 3;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DABBLE,
    OP_TRIM,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_START,
    COND_MORE_BITS,
    COND_LEAD_ZERO,
    COND_MORE_DIGITS
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_step;
    step_t next_step;
  } uword_t;

  // Status flags from the datapath, sampled by the sequencer's jump logic.
  typedef struct packed {
    logic more_bits;
    logic lead_zero;
    logic more_digits;
  } dp_status_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } dp_ctrl_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DABBLE = 3'd1;
  localparam step_t STEP_TRIM   = 3'd2;
  localparam step_t STEP_SIGN   = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;

  function automatic uword_t uc_rom(input step_t s);
    uword_t w;
    case (s)
      STEP_IDLE:   w = '{OP_IDLE,   COND_START,       STEP_DABBLE, STEP_IDLE};
      STEP_DABBLE: w = '{OP_DABBLE, COND_MORE_BITS,   STEP_DABBLE, STEP_TRIM};
      STEP_TRIM:   w = '{OP_TRIM,   COND_LEAD_ZERO,   STEP_TRIM,   STEP_SIGN};
      STEP_SIGN:   w = '{OP_SIGN,   COND_NONE,        STEP_EMIT,   STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,   COND_MORE_DIGITS, STEP_EMIT,   STEP_IDLE};
      default:     w = '{OP_IDLE,   COND_NONE,        STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/sitd_datapath.sv =====
// Datapath for the decimal text block: binary to BCD by shift-and-add-3,
// leading zero removal and character output registers.
// Depends on sitd_pkg.
module sitd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  sitd_pkg::dp_ctrl_t                 ctrl,
  input  logic signed [sitd_pkg::VALUE_W-1:0] value,
  output sitd_pkg::dp_status_t               status,
  output logic                               strobe,
  output logic [7:0]                         ascii_char,
  output logic                               is_last,
  output logic [3:0]                         total_length
);
  import sitd_pkg::*;

  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt;
  logic [ND_W-1:0]    nd;
  logic [3:0]         total;
  logic               neg;
  logic [3:0]         top_digit;

  assign top_digit = bcd[BCD_W-1 -: 4];

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign status.more_bits   = (cnt != CNT_W'(VALUE_W - 1));
  assign status.lead_zero   = (top_digit == 4'd0) && (nd != ND_W'(1));
  assign status.more_digits = (nd != ND_W'(1));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg <= value[VALUE_W-1];
      mag <= value[VALUE_W-1] ? (~value + 1'b1) : value;
      bcd <= '0;
      cnt <= '0;
      nd  <= ND_W'(NUM_DIGITS);
    end else begin
      case (ctrl.op)
        OP_DABBLE: begin
          bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
          mag <= {mag[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
        OP_TRIM: begin
          if (status.lead_zero) begin
            bcd <= {bcd[BCD_W-5:0], 4'd0};
            nd  <= nd - 1'b1;
          end
        end
        OP_SIGN: begin
          total <= nd + {3'd0, neg};
        end
        OP_EMIT: begin
          bcd <= {bcd[BCD_W-5:0], 4'd0};
          nd  <= nd - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (ctrl.op == OP_EMIT) || ((ctrl.op == OP_SIGN) && neg);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_SIGN) begin
      ascii_char   <= CHAR_MINUS;
      is_last      <= 1'b0;
      total_length <= 4'd0;
    end else begin
      ascii_char   <= CHAR_ZERO + {4'd0, top_digit};
      is_last      <= !status.more_digits;
      total_length <= status.more_digits ? 4'd0 : total;
    end
  end

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal text block: microprogram
// sequencer driving the datapath. Depends on sitd_pkg and sitd_datapath.
//
// A value is taken when start is high while busy is low. Its text follows as
// one character per cycle on ascii_char, each marked by a one-cycle strobe:
// a '-' for a negative value, then the digits without leading zeros, the last
// one carrying is_last and total_length. The receiver cannot stall, so every
// strobed character must be taken in its cycle. After the accepting edge busy
// stays high until the last step is done, so no new item is taken while one is
// still being converted. The steps run in order: the shift-and-add-3 loop over
// the 32 bits of the value, one step for each leading zero digit removed plus one
// that finds the first significant digit, one sign step and one step per
// digit. The leading zeros and the digits always add up to ten, so the time
// does not depend on the value. The last character is strobed in the first
// idle cycle, when the next item may already be taken.
module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sitd_pkg::VALUE_W-1:0] value,
  output logic                                strobe,
  output logic [7:0]                          ascii_char,
  output logic                                is_last,
  output logic [3:0]                          total_length
);
  import sitd_pkg::*;

  step_t      step;
  step_t      step_next;
  uword_t     uword;
  logic       cond_true;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign uword = uc_rom(step);
  assign busy  = (uword.op != OP_IDLE);

  always_comb begin
    case (uword.cond)
      COND_START:       cond_true = start;
      COND_MORE_BITS:   cond_true = status.more_bits;
      COND_LEAD_ZERO:   cond_true = status.lead_zero;
      COND_MORE_DIGITS: cond_true = status.more_digits;
      default:          cond_true = 1'b0;
    endcase
    step_next = cond_true ? uword.jump_step : uword.next_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op   = uword.op;
  assign ctrl.load = (uword.op == OP_IDLE) && start;

  sitd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .value        (value),
    .status       (status),
    .strobe       (strobe),
    .ascii_char   (ascii_char),
    .is_last      (is_last),
    .total_length (total_length)
  );

endmodule

// ===== sv/sitd_checker.sv =====
// Port-level checks for the signed integer to decimal text block, bound to
// the top level. Depends on sitd_pkg and signed_int_to_decimal_ascii.
module sitd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [7:0]  ascii_char,
  input logic        is_last,
  input logic [3:0]  total_length
);
  import sitd_pkg::*;

  // An accepted item keeps the block busy on the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // The final character appears just as the block goes idle, others while busy.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (is_last == !busy))
    else $error("last mark out of step with busy");

  a_len_only_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |-> total_length == 4'd0)
    else $error("length shown on a character that is not the last");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    strobe && is_last |-> (total_length != 4'd0) && (total_length <= 4'd11))
    else $error("length out of range on the last character");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (ascii_char == CHAR_MINUS) ||
               ((ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_ZERO + 8'd9)))
    else $error("character outside the minus sign and the digits");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .ascii_char   (ascii_char),
  .is_last      (is_last),
  .total_length (total_length)
);

// ===== tb/sv/tb_signed_int_to_decimal_ascii.sv =====
// Self-checking testbench for signed_int_to_decimal_ascii: a table of directed
// values, then random ones, compared per character with the text given in the
// row or else one from a local predictor. Depends on sitd_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
  import sitd_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic [3:0] len;
  } text_char_t;

  // One directed row: the value and, where it is plain to see, its text.
  typedef struct {
    logic [VALUE_W-1:0] val;
    string              text;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      strobe;
  logic [7:0]                ascii_char;
  logic                      is_last;
  logic [3:0]                total_length;

  text_char_t pending_chars[$];
  int         errors = 0;
  int         cycles = 0;

  stim_row_t directed_rows [20] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{-32'sd1,        "-1"},
    '{32'd2147483647, "2147483647"},
    '{32'h80000000,   "-2147483648"},
    '{-32'sd2147483647, ""},
    '{32'd9,          ""},
    '{32'd10,         ""},
    '{-32'sd10,       ""},
    '{32'd99,         ""},
    '{32'd100,        ""},
    '{32'd999999999,  ""},
    '{32'd1000000000, ""},
    '{-32'sd1000000000, ""},
    '{32'd1234567890, ""},
    '{-32'sd987654321, ""},
    '{32'h55555555,   ""},
    '{32'hAAAAAAAA,   ""},
    '{32'd42,         ""},
    '{-32'sd7,        ""}
  };

  signed_int_to_decimal_ascii DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .strobe       (strobe),
    .ascii_char   (ascii_char),
    .is_last      (is_last),
    .total_length (total_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii verification failed");
      $finish;
    end
  end

  // Works out the characters of one value: sign, then digits without leading zeros.
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits [NUM_DIGITS];
    int                 nd;
    int                 total;
    text_char_t         c;
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < NUM_DIGITS);
    total = nd + (v[VALUE_W-1] ? 1 : 0);
    if (v[VALUE_W-1]) begin
      c = '{CHAR_MINUS, 1'b0, 4'd0};
      pending_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch   = CHAR_ZERO + 8'(digits[i]);
      c.last = (i == 0);
      c.len  = (i == 0) ? 4'(total) : 4'd0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.ch   = text[i];
      c.last = (i == text.len() - 1);
      c.len  = c.last ? 4'(text.len()) : 4'd0;
      pending_chars.push_back(c);
    end
  endfunction

  // Mostly short gaps, some long enough to land on any step of a conversion.
  function automatic int draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 50);
    return $urandom_range(51, 120);
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    int unsigned kind;
    int unsigned nd;
    longint      lo;
    longint      hi;
    longint      m;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom;
    if (kind == 9 && $urandom_range(0, 3) == 0) return 32'h80000000;
    nd = $urandom_range(1, 10);
    lo = 1;
    repeat (nd - 1) lo = lo * 10;
    if (kind < 8) begin
      // A magnitude with a chosen number of digits.
      hi = (lo * 10) - 1;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      if (nd == 1) lo = 0;
      m = lo + (longint'($urandom) % (hi - lo + 1));
    end else begin
      // Either side of a power of ten, where the digit count changes.
      m = lo + longint'($urandom_range(0, 2)) - 1;
    end
    if ($urandom_range(0, 1) == 1) m = -m;
    return m[VALUE_W-1:0];
  endfunction

  // Offers one item after the given gap and books its text once it is taken.
  task automatic send_item(input logic [VALUE_W-1:0] v, input string text, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    if (text.len() > 0) queue_typed_text(text);
    else predict_text(v);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    text_char_t e;
    if (!rst && strobe === 1'b1) begin
      if (pending_chars.size() == 0) begin
        $error("character %0d strobed with nothing expected", ascii_char);
        errors++;
      end else begin
        e = pending_chars.pop_front();
        check_field("ascii_char", e.ch, ascii_char);
        check_field("is_last", 8'(e.last), 8'(is_last));
        check_field("total_length", 8'(e.len), 8'(total_length));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_item(directed_rows[i].val, directed_rows[i].text, draw_gap());
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every third block of forty items runs back to back with no gaps.
      send_item(draw_value(), "", ((i / 40) % 3 == 1) ? 0 : draw_gap());
    end
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("signed_int_to_decimal_ascii verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule
